// ----- sv/b2a_pkg.sv -----
// Shared types, constants and helpers for the binary-to-ASCII formatter.
`timescale 1ns / 1ps
`default_nettype none
package b2a_pkg;

  localparam int unsigned VALUE_W        = 32;
  localparam int unsigned DIGITS         = 10;
  localparam int unsigned BCD_W          = 4 * DIGITS;
  localparam int unsigned BITS_PER_STAGE = 4;
  localparam int unsigned NUM_STAGES     = VALUE_W / BITS_PER_STAGE;

  localparam logic [2:0] KIND_HEX8  = 3'd0;
  localparam logic [2:0] KIND_HEX16 = 3'd1;
  localparam logic [2:0] KIND_HEX32 = 3'd2;
  localparam logic [2:0] KIND_DEC16 = 3'd3;
  localparam logic [2:0] KIND_DEC32 = 3'd4;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_A    = 8'h61;

  // Word moving down the conversion pipeline.
  typedef struct packed {
    logic [2:0]         kind;
    logic [VALUE_W-1:0] value;   // original value, used for hex
    logic [VALUE_W-1:0] shreg;   // binary bits still to shift into bcd
    logic [BCD_W-1:0]   bcd;
  } item_t;

  function automatic logic [7:0] nibble_char(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'ha) begin
      c = ASCII_ZERO + {4'd0, n};
    end else begin
      c = ASCII_A + {4'd0, n - 4'ha};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- sv/b2a_dabble_stage.sv -----
// One pipeline stage of the shift-and-add-3 binary to BCD conversion.
`timescale 1ns / 1ps
`default_nettype none
module b2a_dabble_stage (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire b2a_pkg::item_t  in_item,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output b2a_pkg::item_t       out_item
);

  logic           valid_r;
  b2a_pkg::item_t item_r;
  b2a_pkg::item_t item_nxt;

  always_comb begin
    item_nxt = in_item;
    for (int b = 0; b < b2a_pkg::BITS_PER_STAGE; b++) begin
      for (int d = 0; d < b2a_pkg::DIGITS; d++) begin
        if (item_nxt.bcd[4*d +: 4] >= 4'd5) begin
          item_nxt.bcd[4*d +: 4] = item_nxt.bcd[4*d +: 4] + 4'd3;
        end
      end
      item_nxt.bcd   = {item_nxt.bcd[b2a_pkg::BCD_W-2:0],
                        item_nxt.shreg[b2a_pkg::VALUE_W-1]};
      item_nxt.shreg = {item_nxt.shreg[b2a_pkg::VALUE_W-2:0], 1'b0};
    end
  end

  // Hold when full and the next stage is stalled.
  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule
`default_nettype wire

// ----- sv/b2a_serializer.sv -----
// Turns one converted word into a stream of ASCII characters.
`timescale 1ns / 1ps
`default_nettype none
module b2a_serializer (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire b2a_pkg::item_t  in_item,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [7:0]           out_char_code,
  output logic                 out_last
);

  logic       busy_r;
  logic [3:0] digs_r [b2a_pkg::DIGITS];
  logic [3:0] pos_r;
  logic       oval_r;
  logic [7:0] char_r;
  logic       last_r;

  logic       out_take;
  logic       load;
  logic       load_busy;
  logic [3:0] pos_nxt;
  logic [3:0] digs_nxt [b2a_pkg::DIGITS];

  assign out_take = !oval_r || out_ready;
  assign in_ready = !busy_r || (pos_r == 4'd0 && out_take);
  assign load     = in_valid && in_ready;

  always_comb begin
    load_busy = 1'b1;
    pos_nxt   = 4'd0;
    for (int d = 0; d < b2a_pkg::DIGITS; d++) begin
      digs_nxt[d] = 4'd0;
    end
    case (in_item.kind)
      b2a_pkg::KIND_HEX8, b2a_pkg::KIND_HEX16, b2a_pkg::KIND_HEX32: begin
        for (int d = 0; d < b2a_pkg::VALUE_W / 4; d++) begin
          digs_nxt[d] = in_item.value[4*d +: 4];
        end
        if (in_item.kind == b2a_pkg::KIND_HEX8) begin
          pos_nxt = 4'd1;
        end else if (in_item.kind == b2a_pkg::KIND_HEX16) begin
          pos_nxt = 4'd3;
        end else begin
          pos_nxt = 4'd7;
        end
      end
      b2a_pkg::KIND_DEC16, b2a_pkg::KIND_DEC32: begin
        for (int d = 0; d < b2a_pkg::DIGITS; d++) begin
          digs_nxt[d] = in_item.bcd[4*d +: 4];
          if (in_item.bcd[4*d +: 4] != 4'd0) begin
            pos_nxt = 4'(d);
          end
        end
      end
      default: begin
        // drop the word: unused kind gives no characters
        load_busy = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      oval_r <= 1'b0;
    end else begin
      if (load) begin
        busy_r <= load_busy;
      end else if (busy_r && out_take && pos_r == 4'd0) begin
        busy_r <= 1'b0;
      end
      if (out_take) begin
        oval_r <= busy_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_take && busy_r) begin
      char_r <= b2a_pkg::nibble_char(digs_r[pos_r]);
      last_r <= (pos_r == 4'd0);
    end
    if (load) begin
      digs_r <= digs_nxt;
      pos_r  <= pos_nxt;
    end else if (out_take && busy_r && pos_r != 4'd0) begin
      pos_r <= pos_r - 4'd1;
    end
  end

  assign out_valid     = oval_r;
  assign out_char_code = char_r;
  assign out_last      = last_r;

endmodule
`default_nettype wire

// ----- sv/binary_to_ascii_number_formatter.sv -----
// Top level: binary value to ASCII hex or decimal character stream.
// Usage:
//   Input channel (in_valid/in_ready): one word per value, in_kind picks
//   hex8, hex16, hex32 (fixed 2/4/8 lowercase digits) or dec16, dec32
//   (1 to 5 or 1 to 10 digits, no leading zeros). Kinds 5..7 are taken
//   and produce nothing.
//   Output channel (out_valid/out_ready): one ASCII character per word,
//   out_last high on the final character of each value.
//   Path: the first character passes through 8 BCD stages of 4 bits
//   each, a load stage and the output register.
//   Throughput: one character per cycle while out_ready is high; the
//   characters of a value (1 to 10) leave one after another through the
//   single character-wide output register. Values enter every cycle while
//   the pipeline has room.
//   Stall: when out_ready is low the output register holds, the
//   serializer holds, and the BCD stages fill up and then drop in_ready.
//   Nothing is lost or repeated.
//   Reset: synchronous active-low rst_n empties all stages; the block
//   keeps no state between values.
`timescale 1ns / 1ps
`default_nettype none
module binary_to_ascii_number_formatter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_kind,
  input  wire logic [31:0] in_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_char_code,
  output logic             out_last
);

  localparam int unsigned NS = b2a_pkg::NUM_STAGES;

  b2a_pkg::item_t stg_item  [NS+1];
  logic           stg_valid [NS+1];
  logic           stg_ready [NS+1];

  always_comb begin
    stg_item[0].kind  = in_kind;
    stg_item[0].value = in_value;
    stg_item[0].bcd   = '0;
    if (in_kind == b2a_pkg::KIND_DEC16) begin
      stg_item[0].shreg = {16'd0, in_value[15:0]};
    end else begin
      stg_item[0].shreg = in_value;
    end
  end

  assign stg_valid[0] = in_valid;
  assign in_ready     = stg_ready[0];

  for (genvar i = 0; i < NS; i++) begin : g_stage
    b2a_dabble_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (stg_valid[i]),
      .in_ready  (stg_ready[i]),
      .in_item   (stg_item[i]),
      .out_valid (stg_valid[i+1]),
      .out_ready (stg_ready[i+1]),
      .out_item  (stg_item[i+1])
    );
  end

  b2a_serializer u_ser (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (stg_valid[NS]),
    .in_ready      (stg_ready[NS]),
    .in_item       (stg_item[NS]),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char_code (out_char_code),
    .out_last      (out_last)
  );

endmodule
`default_nettype wire
